// File: hdl/ihq_pkg.sv
// Shared widths, defaults and codes for the indexed min-heap queue.
`default_nettype none

package ihq_pkg;

    localparam int KEY_W             = 6;
    localparam int PRIO_PORT_W       = 32;
    localparam int TOTAL_W           = 7;
    localparam int STATUS_W          = 3;
    localparam int CAPACITY_DEF      = 64;
    localparam int KEY_COUNT_DEF     = 64;
    localparam int PRIORITY_BITS_DEF = 32;

    typedef enum logic [1:0] {
        KIND_PUSH     = 2'd0,
        KIND_POP      = 2'd1,
        KIND_DECREASE = 2'd2,
        KIND_NOP      = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_ABSENT  = 3'd3,
        ST_PRESENT = 3'd4
    } status_t;

endpackage

`default_nettype wire

// File: hdl/ihq_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none

module ihq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write first in program order, read old contents on the same edge
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: hdl/indexed_min_heap_queue.sv
// Indexed binary min-heap queue: heap and key-position map in RAMs, walked by a sequencer.
// Push and decrease move the entry up level by level until it settles or reaches the root;
// pop moves the last entry to the root and sifts it down, reading the left child and then
// the right child where there is one, until it settles or stops at a leaf.
// Pop of the last entry, failed operations and kind 3 go straight to the result; one item at a time.
// Reset is asynchronous, active low; the map is then cleared key by key, input stalled.
`default_nettype none

module indexed_min_heap_queue
    import ihq_pkg::*;
#(
    parameter int CAPACITY      = CAPACITY_DEF,
    parameter int KEY_COUNT     = KEY_COUNT_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [1:0]             kind,
    input  wire logic [KEY_W-1:0]       key,
    input  wire logic [PRIO_PORT_W-1:0] priority_req,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [KEY_W-1:0]            front_key,
    output logic [PRIO_PORT_W-1:0]      front_priority,
    output logic                        is_empty,
    output logic [TOTAL_W-1:0]          entry_total,
    output logic [STATUS_W-1:0]         status
);

    localparam int HA_W  = $clog2(CAPACITY);
    localparam int KI_W  = $clog2(KEY_COUNT);
    localparam int POS_W = $clog2(CAPACITY + 1);
    localparam int CH_W  = POS_W + 1;
    localparam int HW    = KEY_W + PRIORITY_BITS;

    typedef enum logic [10:0] {
        S_CLEAR    = 11'b000_0000_0001,
        S_IDLE     = 11'b000_0000_0010,
        S_DECODE   = 11'b000_0000_0100,
        S_POP_LAST = 11'b000_0000_1000,
        S_UP_RD    = 11'b000_0001_0000,
        S_UP_CMP   = 11'b000_0010_0000,
        S_DN_L     = 11'b000_0100_0000,
        S_DN_R     = 11'b000_1000_0000,
        S_DN_PICK  = 11'b001_0000_0000,
        S_DN_CMP   = 11'b010_0000_0000,
        S_DONE     = 11'b100_0000_0000
    } state_t;

    // Control registers
    state_t               state_reg, state_next;
    logic [KI_W-1:0]      clr_reg, clr_next;
    logic [POS_W-1:0]     count_reg, count_next;
    logic                 out_valid_reg, out_valid_next;

    // Payload registers
    kind_t                kind_reg, kind_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [PRIORITY_BITS-1:0] prio_reg, prio_next;
    logic [KEY_W-1:0]     cur_key_reg, cur_key_next;
    logic [PRIORITY_BITS-1:0] cur_prio_reg, cur_prio_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [KEY_W-1:0]     ch_key_reg, ch_key_next;
    logic [PRIORITY_BITS-1:0] ch_prio_reg, ch_prio_next;
    logic [POS_W-1:0]     pick_reg, pick_next;
    status_t              st_reg, st_next;
    logic [KEY_W-1:0]     root_key_reg, root_key_next;
    logic [PRIORITY_BITS-1:0] root_prio_reg, root_prio_next;
    logic [KEY_W-1:0]     fkey_reg, fkey_next;
    logic [PRIORITY_BITS-1:0] fprio_reg, fprio_next;
    logic                 empty_reg, empty_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    status_t              ost_reg, ost_next;

    // RAM ports
    logic                 hw_en;
    logic [HA_W-1:0]      hw_addr;
    logic [HW-1:0]        hw_data;
    logic [HA_W-1:0]      hr_addr;
    logic [HW-1:0]        hr_data;
    logic                 mw_en;
    logic [KI_W-1:0]      mw_addr;
    logic [POS_W-1:0]     mw_data;
    logic [KI_W-1:0]      mr_addr;
    logic [POS_W-1:0]     mr_data;

    logic [KEY_W-1:0]     rd_key;
    logic [PRIORITY_BITS-1:0] rd_prio;
    logic [CH_W-1:0]      left_pos;
    logic [CH_W-1:0]      right_pos;
    logic                 key_ok;
    logic                 accept;

    ihq_ram #(
        .WIDTH (HW),
        .DEPTH (CAPACITY)
    ) u_heap (
        .clk     (clk),
        .wr_en   (hw_en),
        .wr_addr (hw_addr),
        .wr_data (hw_data),
        .rd_addr (hr_addr),
        .rd_data (hr_data)
    );

    ihq_ram #(
        .WIDTH (POS_W),
        .DEPTH (KEY_COUNT)
    ) u_map (
        .clk     (clk),
        .wr_en   (mw_en),
        .wr_addr (mw_addr),
        .wr_data (mw_data),
        .rd_addr (mr_addr),
        .rd_data (mr_data)
    );

    assign rd_key    = hr_data[HW-1:PRIORITY_BITS];
    assign rd_prio   = hr_data[PRIORITY_BITS-1:0];
    assign left_pos  = {pos_reg, 1'b0};
    assign right_pos = {pos_reg, 1'b1};
    assign key_ok    = (32'(key_reg) < 32'(KEY_COUNT));
    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        key_next       = key_reg;
        prio_next      = prio_reg;
        cur_key_next   = cur_key_reg;
        cur_prio_next  = cur_prio_reg;
        pos_next       = pos_reg;
        ch_key_next    = ch_key_reg;
        ch_prio_next   = ch_prio_reg;
        pick_next      = pick_reg;
        st_next        = st_reg;
        fkey_next      = fkey_reg;
        fprio_next     = fprio_reg;
        empty_next     = empty_reg;
        total_next     = total_reg;
        ost_next       = ost_reg;

        hw_en   = 1'b0;
        hw_addr = HA_W'(pos_reg - POS_W'(1));
        hw_data = {cur_key_reg, cur_prio_reg};
        hr_addr = '0;
        mw_en   = 1'b0;
        mw_addr = KI_W'(cur_key_reg);
        mw_data = pos_reg;
        mr_addr = KI_W'(key);

        unique case (state_reg)
            S_CLEAR:
            begin
                mw_en    = 1'b1;
                mw_addr  = clr_reg;
                mw_data  = '0;
                clr_next = clr_reg + KI_W'(1);
                if (clr_reg == KI_W'(KEY_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                // Look up the key and the root while the transaction is decoded
                if (accept)
                begin
                    kind_next  = kind_t'(kind);
                    key_next   = key;
                    prio_next  = PRIORITY_BITS'(priority_req);
                    st_next    = ST_OK;
                    state_next = (kind_t'(kind) == KIND_NOP) ? S_DONE : S_DECODE;
                end
            end

            S_DECODE:
            begin
                cur_key_next  = key_reg;
                cur_prio_next = prio_reg;
                unique case (kind_reg)
                    KIND_PUSH:
                    begin
                        if (!key_ok)
                        begin
                            st_next    = ST_ABSENT;
                            state_next = S_DONE;
                        end
                        else if (mr_data != '0)
                        begin
                            st_next    = ST_PRESENT;
                            state_next = S_DONE;
                        end
                        else if (count_reg >= POS_W'(CAPACITY))
                        begin
                            st_next    = ST_FULL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            count_next = count_reg + POS_W'(1);
                            pos_next   = count_reg + POS_W'(1);
                            state_next = S_UP_RD;
                        end
                    end
                    KIND_DECREASE:
                    begin
                        if (!key_ok || mr_data == '0 || mr_data > count_reg)
                        begin
                            st_next    = ST_ABSENT;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            pos_next   = mr_data;
                            state_next = S_UP_RD;
                        end
                    end
                    KIND_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            st_next    = ST_EMPTY;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            // Drop the departing key from the map
                            mw_en      = 1'b1;
                            mw_addr    = KI_W'(rd_key);
                            mw_data    = '0;
                            count_next = count_reg - POS_W'(1);
                            if (count_reg == POS_W'(1))
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                hr_addr    = HA_W'(count_reg - POS_W'(1));
                                state_next = S_POP_LAST;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_POP_LAST:
            begin
                cur_key_next  = rd_key;
                cur_prio_next = rd_prio;
                pos_next      = POS_W'(1);
                state_next    = S_DN_L;
            end

            S_UP_RD:
            begin
                if (pos_reg == POS_W'(1))
                begin
                    hw_en      = 1'b1;
                    mw_en      = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    hr_addr    = HA_W'((pos_reg >> 1) - POS_W'(1));
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                if (cur_prio_reg < rd_prio)
                begin
                    // Move the parent down into the hole
                    hw_en      = 1'b1;
                    hw_data    = hr_data;
                    mw_en      = 1'b1;
                    mw_addr    = KI_W'(rd_key);
                    pos_next   = pos_reg >> 1;
                    state_next = S_UP_RD;
                end
                else
                begin
                    hw_en      = 1'b1;
                    mw_en      = 1'b1;
                    state_next = S_DONE;
                end
            end

            S_DN_L:
            begin
                if (left_pos > CH_W'(count_reg))
                begin
                    hw_en      = 1'b1;
                    mw_en      = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    hr_addr    = HA_W'(left_pos - CH_W'(1));
                    state_next = S_DN_R;
                end
            end

            S_DN_R:
            begin
                ch_key_next  = rd_key;
                ch_prio_next = rd_prio;
                pick_next    = POS_W'(left_pos);
                if (right_pos <= CH_W'(count_reg))
                begin
                    hr_addr    = HA_W'(right_pos - CH_W'(1));
                    state_next = S_DN_PICK;
                end
                else
                begin
                    state_next = S_DN_CMP;
                end
            end

            S_DN_PICK:
            begin
                // Left child wins ties
                if (rd_prio < ch_prio_reg)
                begin
                    ch_key_next  = rd_key;
                    ch_prio_next = rd_prio;
                    pick_next    = POS_W'(right_pos);
                end
                state_next = S_DN_CMP;
            end

            S_DN_CMP:
            begin
                if (ch_prio_reg < cur_prio_reg)
                begin
                    // Move the smaller child up into the hole
                    hw_en      = 1'b1;
                    hw_data    = {ch_key_reg, ch_prio_reg};
                    mw_en      = 1'b1;
                    mw_addr    = KI_W'(ch_key_reg);
                    pos_next   = pick_reg;
                    state_next = S_DN_L;
                end
                else
                begin
                    hw_en      = 1'b1;
                    mw_en      = 1'b1;
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                // Hand the result over once the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    empty_next     = (count_reg == '0);
                    fkey_next      = (count_reg == '0) ? '0 : root_key_reg;
                    fprio_next     = (count_reg == '0) ? '0 : root_prio_reg;
                    total_next     = TOTAL_W'(count_reg);
                    ost_next       = st_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Mirror the root slot in registers
    always_comb
    begin
        root_key_next  = root_key_reg;
        root_prio_next = root_prio_reg;
        if (hw_en && hw_addr == '0)
        begin
            root_key_next  = hw_data[HW-1:PRIORITY_BITS];
            root_prio_next = hw_data[PRIORITY_BITS-1:0];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        key_reg       <= key_next;
        prio_reg      <= prio_next;
        cur_key_reg   <= cur_key_next;
        cur_prio_reg  <= cur_prio_next;
        pos_reg       <= pos_next;
        ch_key_reg    <= ch_key_next;
        ch_prio_reg   <= ch_prio_next;
        pick_reg      <= pick_next;
        st_reg        <= st_next;
        root_key_reg  <= root_key_next;
        root_prio_reg <= root_prio_next;
        fkey_reg      <= fkey_next;
        fprio_reg     <= fprio_next;
        empty_reg     <= empty_next;
        total_reg     <= total_next;
        ost_reg       <= ost_next;
    end

    assign out_valid      = out_valid_reg;
    assign front_key      = fkey_reg;
    assign front_priority = PRIO_PORT_W'(fprio_reg);
    assign is_empty       = empty_reg;
    assign entry_total    = total_reg;
    assign status         = ost_reg;

endmodule

`default_nettype wire

// File: hdl/ihq_checker.sv
// Port-level checker for the indexed min-heap queue, bound to the top level.
`default_nettype none

module ihq_checker
    import ihq_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   out_valid,
    input wire logic                   out_stall,
    input wire logic [KEY_W-1:0]       front_key,
    input wire logic [PRIO_PORT_W-1:0] front_priority,
    input wire logic                   is_empty,
    input wire logic [TOTAL_W-1:0]     entry_total,
    input wire logic [STATUS_W-1:0]    status
);

    // A stalled result keeps its front key, count and status
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(front_key)
            && $stable(entry_total) && $stable(status))
        else $error("stalled result changed");

    // Empty flag tracks the count
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_empty == (entry_total == '0)))
        else $error("empty flag disagrees with count");

    // Empty queue shows a zero front
    a_empty_front: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_empty |-> (front_key == '0) && (front_priority == '0))
        else $error("empty queue shows a front entry");

    // Pop on empty leaves the queue empty
    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY) |-> is_empty)
        else $error("pop-empty status with entries held");

endmodule

bind indexed_min_heap_queue ihq_checker u_ihq_checker (.*);

`default_nettype wire
